### src/csq_pkg.sv
// csq_pkg: command, error and shift-op codes and the command/response word
// types for the cursor sequence store. No dependencies.
package csq_pkg;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_ADVANCE = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_ATTACH  = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_READ    = 3'd5
	} csq_cmd_t;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_FULL       = 2'd1,
		ERR_NO_CURRENT = 2'd2
	} csq_err_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} csq_op_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] entry_value;
	} csq_in_t;

	typedef struct packed {
		logic [31:0] current_value;
		logic        has_current;
		logic [5:0]  item_count;
		logic [1:0]  error_code;
	} csq_out_t;

endpackage

### src/csq_slot.sv
// csq_slot: one storage slot of the list. Opens a gap by taking its lower
// neighbor, closes one by taking its upper neighbor. Uses csq_pkg.
module csq_slot #(
	parameter int SLOT_INDEX = 0,
	parameter int IDX_W      = 5,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  csq_pkg::csq_op_t      op,
	input  logic [IDX_W-1:0]      pos,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [VALUE_BITS-1:0] lower_value,
	input  logic [VALUE_BITS-1:0] upper_value,
	output logic [VALUE_BITS-1:0] value
);
	import csq_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_INDEX);

	logic [VALUE_BITS-1:0] value_q;
	logic                  above;
	logic                  at_pos;

	assign above  = MY_IDX > pos;
	assign at_pos = MY_IDX == pos;
	assign value  = value_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_OPEN: begin
				if (above) begin
					value_q <= lower_value;
				end else if (at_pos) begin
					value_q <= wr_value;
				end
			end
			OP_CLOSE: begin
				if (above || at_pos) begin
					value_q <= upper_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### src/cursor_sequence_store_unit.sv
// cursor_sequence_store_unit: ordered list with a cursor, built as a row of
// csq_slot storage slots plus cursor/count control. Uses csq_pkg, csq_slot.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_word) takes one command word:
//   start, advance, insert before, attach after, remove, or read.
//   rsp channel (rsp_valid/rsp_ready/rsp_word) returns one word per command:
//   current value, has-current flag, item count and error code.
//   The command updates the slot row in the cycle it is accepted; every slot
//   shifts in parallel with its neighbor, so any insert or remove is a single
//   update of the row. The response word is then registered in the output
//   register once that is free, read out of the slot at the cursor.
//   A new command is taken only after the previous response is loaded into
//   the output register, also while that response still waits there; a
//   stalled rsp_ready holds the readout of the next and, until it is done,
//   the taking of a further command.
//   Reset (arst_n low) empties the list and parks the cursor at the front;
//   slot contents are not cleared and are never read before written.
//   Errors (full store, no current item) leave the list and cursor as is.
module cursor_sequence_store_unit #(
	parameter int CAPACITY_ITEMS = 32,
	parameter int VALUE_BITS     = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  csq_pkg::csq_in_t  cmd_word,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output csq_pkg::csq_out_t rsp_word
);
	import csq_pkg::*;

	localparam int IDX_W  = $clog2(CAPACITY_ITEMS);
	localparam int CNT_W  = $clog2(CAPACITY_ITEMS + 1);
	localparam int KEEP_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY_ITEMS);

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cur_q;
	logic                  pend_q;
	csq_err_t              err_q;
	logic                  rsp_valid_q;
	csq_out_t              rsp_word_q;

	logic                  accept;
	logic                  load;
	logic                  is_item;
	logic                  full;
	csq_op_t               op;
	logic [IDX_W-1:0]      pos;
	logic [CNT_W-1:0]      cnt_d;
	logic [CNT_W-1:0]      cur_d;
	csq_err_t              err_d;
	logic [VALUE_BITS-1:0] wr_value;
	logic [VALUE_BITS-1:0] slot_val [CAPACITY_ITEMS];
	logic                  has_cur;
	logic [VALUE_BITS-1:0] cur_val;

	assign cmd_ready = !pend_q;
	assign accept    = cmd_valid && cmd_ready;
	assign load      = pend_q && (!rsp_valid_q || rsp_ready);
	assign is_item   = cur_q < cnt_q;
	assign full      = cnt_q >= CAP;
	assign wr_value  = VALUE_BITS'(cmd_word.entry_value[KEEP_W-1:0]);

	always_comb begin
		op    = OP_HOLD;
		pos   = cur_q[IDX_W-1:0];
		cnt_d = cnt_q;
		cur_d = cur_q;
		err_d = ERR_OK;
		case (cmd_word.cmd)
			CMD_START: begin
				cur_d = '0;
			end
			CMD_ADVANCE: begin
				if (!is_item) begin
					err_d = ERR_NO_CURRENT;
				end else begin
					cur_d = CNT_W'(cur_q + 1'b1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					pos   = is_item ? cur_q[IDX_W-1:0] : '0;
					op    = OP_OPEN;
					cur_d = CNT_W'(pos);
					cnt_d = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_ATTACH: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					pos   = is_item ? IDX_W'(cur_q + 1'b1) : cnt_q[IDX_W-1:0];
					op    = OP_OPEN;
					cur_d = CNT_W'(pos);
					cnt_d = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_REMOVE: begin
				if (!is_item) begin
					err_d = ERR_NO_CURRENT;
				end else begin
					op    = OP_CLOSE;
					cnt_d = CNT_W'(cnt_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			op = OP_HOLD;
		end
	end

	for (genvar g = 0; g < CAPACITY_ITEMS; g++) begin : g_slot
		logic [VALUE_BITS-1:0] lower;
		logic [VALUE_BITS-1:0] upper;
		if (g == 0) begin : g_first
			assign lower = wr_value;
		end else begin : g_mid_lo
			assign lower = slot_val[g-1];
		end
		if (g == CAPACITY_ITEMS - 1) begin : g_last
			assign upper = slot_val[g];
		end else begin : g_mid_hi
			assign upper = slot_val[g+1];
		end
		csq_slot #(
			.SLOT_INDEX (g),
			.IDX_W      (IDX_W),
			.VALUE_BITS (VALUE_BITS)
		) u_slot (
			.clk         (clk),
			.op          (op),
			.pos         (pos),
			.wr_value    (wr_value),
			.lower_value (lower),
			.upper_value (upper),
			.value       (slot_val[g])
		);
	end

	assign has_cur = cur_q < cnt_q;
	assign cur_val = has_cur ? slot_val[cur_q[IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cur_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q  <= cnt_d;
				cur_q  <= cur_d;
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_d;
		end
		if (load) begin
			rsp_word_q.current_value <= 32'(cur_val[KEEP_W-1:0]);
			rsp_word_q.has_current   <= has_cur;
			rsp_word_q.item_count    <= 6'(cnt_q);
			rsp_word_q.error_code    <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("item count above capacity");

	a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= cnt_q)
		else $error("cursor beyond item count");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (err_d != ERR_OK) |=> $stable(cnt_q) && $stable(cur_q))
		else $error("failed command changed list state");

	a_no_cur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_word_q.has_current |-> rsp_word_q.current_value == 32'd0)
		else $error("value reported without current item");

endmodule
